@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Each check is sampled on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/tdtk_pkg.sv @@
// Package for the table-keyed TEA decryption pipeline.
// Holds sizes, config register indexes, substitution tables and round helpers.
// No dependencies.
package tdtk_pkg;

    localparam int ROUNDS    = 32;
    localparam int NSTG      = 2 * ROUNDS;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [31:0] SUM_START = 32'hC6EF3720;
    localparam logic [31:0] SUM_DELTA = 32'h9E3779B9;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SET = 1'd1;

    typedef logic [31:0] t_word;

    localparam logic [7:0] SBOX_A [2][256] = '{
        '{
            8'h31,8'h1C,8'h23,8'hE5,8'h89,8'h8E,8'hA1,8'h37,
            8'h74,8'h6D,8'h67,8'hFC,8'h1F,8'hC0,8'hB1,8'h94,
            8'h3B,8'h05,8'h56,8'h86,8'h00,8'h24,8'hF0,8'h17,
            8'h72,8'hA2,8'h3D,8'h1B,8'hE3,8'h17,8'hC5,8'h0B,
            8'hB9,8'hE2,8'hBD,8'h58,8'h71,8'h1B,8'h2C,8'hFF,
            8'hE4,8'hC9,8'h4C,8'h5E,8'hC9,8'h55,8'h33,8'h45,
            8'h7C,8'h3F,8'hB2,8'h51,8'hFE,8'h10,8'h7E,8'h75,
            8'h3C,8'h90,8'h8D,8'hDA,8'h94,8'h38,8'hC3,8'hE9,
            8'h95,8'hEA,8'hCE,8'hA6,8'h06,8'hE0,8'h4F,8'h3F,
            8'h2A,8'hE3,8'h3A,8'hE4,8'h43,8'hBD,8'h7F,8'hDA,
            8'h55,8'hF0,8'hEA,8'hCB,8'h2C,8'hA8,8'h47,8'h61,
            8'hA0,8'hEF,8'hCB,8'h13,8'h18,8'h20,8'hAF,8'h3E,
            8'h4D,8'h9E,8'h1E,8'h77,8'h51,8'hC5,8'h51,8'h20,
            8'hCF,8'h21,8'hF9,8'h39,8'h94,8'hDE,8'hDD,8'h79,
            8'h4E,8'h80,8'hC4,8'h9D,8'h94,8'hD5,8'h95,8'h01,
            8'h27,8'h27,8'hBD,8'h6D,8'h78,8'hB5,8'hD1,8'h31,
            8'h6A,8'h65,8'h74,8'h74,8'h58,8'hB3,8'h7C,8'hC9,
            8'h5A,8'hED,8'h50,8'h03,8'hC4,8'hA2,8'h94,8'h4B,
            8'hF0,8'h58,8'h09,8'h6F,8'h3E,8'h7D,8'hAE,8'h7D,
            8'h58,8'hA0,8'h2C,8'h91,8'hBB,8'hE1,8'h70,8'hEB,
            8'h73,8'hA6,8'h9A,8'h44,8'h25,8'h90,8'h16,8'h62,
            8'h53,8'hAE,8'h08,8'hEB,8'hDC,8'hF0,8'hEE,8'h77,
            8'hC2,8'hDE,8'h81,8'hE8,8'h30,8'h89,8'hDB,8'hFE,
            8'hBC,8'hC2,8'hDF,8'h26,8'hE9,8'h8B,8'hD6,8'h93,
            8'hF0,8'hCB,8'h56,8'h90,8'hC0,8'h46,8'h68,8'h15,
            8'h43,8'hCB,8'hE9,8'h98,8'hE3,8'hAF,8'h31,8'h25,
            8'h4D,8'h7B,8'hF3,8'hB1,8'h74,8'hE2,8'h64,8'hAC,
            8'hD9,8'hF6,8'hA0,8'hD5,8'h0B,8'h9B,8'h49,8'h52,
            8'h69,8'h3B,8'h71,8'h00,8'h2F,8'hBB,8'hBA,8'h08,
            8'hB1,8'hAE,8'hBB,8'hB3,8'hE1,8'hC9,8'hA6,8'h7F,
            8'h17,8'h97,8'h28,8'h72,8'h12,8'h6E,8'h91,8'hAE,
            8'h3A,8'hA2,8'h35,8'h46,8'h27,8'hF8,8'h12,8'h50
        },
        '{
            8'hD0,8'hFF,8'hBA,8'hE5,8'hC1,8'hC7,8'hDB,8'h5B,
            8'h16,8'hE3,8'h6E,8'h26,8'h62,8'h31,8'h2E,8'h2A,
            8'hD1,8'hBB,8'h4A,8'hE6,8'hAE,8'h2F,8'h0A,8'h90,
            8'h29,8'h90,8'hB6,8'h67,8'h58,8'h2A,8'hB4,8'h45,
            8'h7B,8'hCB,8'hF0,8'h73,8'h84,8'h30,8'h81,8'hC2,
            8'hD7,8'hBE,8'h89,8'hD7,8'h4E,8'h73,8'h5C,8'hC7,
            8'h80,8'h1B,8'hE5,8'hE4,8'h43,8'hC7,8'h46,8'hD6,
            8'h6F,8'h7B,8'hBF,8'hED,8'hE5,8'h27,8'hD1,8'hB5,
            8'hD0,8'hD8,8'hA3,8'hCB,8'h2B,8'h30,8'hA4,8'hF0,
            8'h84,8'h14,8'h72,8'h5C,8'hFF,8'hA4,8'hFB,8'h54,
            8'h9D,8'h70,8'hE2,8'hFF,8'hBE,8'hE8,8'h24,8'h76,
            8'hE5,8'h15,8'hFB,8'h1A,8'hBC,8'h87,8'h02,8'h2A,
            8'h58,8'h8F,8'h9A,8'h95,8'hBD,8'hAE,8'h8D,8'h0C,
            8'hA5,8'h4C,8'hF2,8'h5C,8'h7D,8'hAD,8'h51,8'hFB,
            8'hB1,8'h22,8'h07,8'hE0,8'h29,8'h7C,8'hEB,8'h98,
            8'h14,8'hC6,8'h31,8'h97,8'hE4,8'h34,8'h8F,8'hCC,
            8'h99,8'h56,8'h9F,8'h78,8'h43,8'h91,8'h85,8'h3F,
            8'hC2,8'hD0,8'hD1,8'h80,8'hD1,8'h77,8'hA7,8'hE2,
            8'h43,8'h99,8'h1D,8'h2F,8'h8B,8'h6A,8'hE4,8'h66,
            8'h82,8'hF7,8'h2B,8'h0B,8'h65,8'h14,8'hC0,8'hC2,
            8'h1D,8'h96,8'h78,8'h1C,8'hC4,8'hC3,8'hD2,8'hB1,
            8'h64,8'h07,8'hD7,8'h6F,8'h02,8'hE9,8'h44,8'h31,
            8'hDB,8'h3C,8'hEB,8'h93,8'hED,8'h9A,8'h57,8'h05,
            8'hB9,8'h0E,8'hAF,8'h1F,8'h48,8'h11,8'hDC,8'h35,
            8'h6C,8'hB8,8'hEE,8'h2A,8'h48,8'h2B,8'hBC,8'h89,
            8'h12,8'h59,8'hCB,8'hD1,8'h18,8'hEA,8'h72,8'h11,
            8'h01,8'h75,8'h3B,8'hB5,8'h56,8'hF4,8'h8B,8'hA0,
            8'h41,8'h75,8'h86,8'h7B,8'h94,8'h12,8'h2D,8'h4C,
            8'h0C,8'h22,8'hC9,8'h4A,8'hD8,8'hB1,8'h8D,8'hF0,
            8'h55,8'h2E,8'h77,8'h50,8'h1C,8'h64,8'h77,8'hAA,
            8'h3E,8'hAC,8'hD3,8'h3D,8'hCE,8'h60,8'hCA,8'h5D,
            8'hA0,8'h92,8'h78,8'hC6,8'h51,8'hFE,8'hF9,8'h30
        }
    };

    localparam logic [7:0] SBOX_B [2][256] = '{
        '{
            8'hD8,8'h65,8'h04,8'hC2,8'h65,8'hD5,8'hB0,8'h0C,
            8'hDF,8'h9D,8'hF0,8'hC3,8'h9A,8'h17,8'hC9,8'hA6,
            8'hE1,8'hAC,8'h0D,8'h14,8'h2F,8'h3C,8'h2C,8'h87,
            8'hA2,8'hBF,8'h4D,8'h5F,8'hAC,8'h2D,8'h9D,8'hE1,
            8'h0C,8'h9C,8'hE7,8'h7F,8'hFC,8'hA8,8'h66,8'h59,
            8'hAC,8'h18,8'hD7,8'h05,8'hF0,8'hBF,8'hD1,8'h8B,
            8'h35,8'h9F,8'h59,8'hB4,8'hBA,8'h55,8'hB2,8'h85,
            8'hFD,8'hB1,8'h72,8'h06,8'h73,8'hA4,8'hDB,8'h48,
            8'h7B,8'h5F,8'h67,8'hA5,8'h95,8'hB9,8'hA5,8'h4A,
            8'hCF,8'hD1,8'h44,8'hF3,8'h81,8'hF5,8'h6D,8'hF6,
            8'h3A,8'hC3,8'h57,8'h83,8'hFA,8'h8E,8'h15,8'h2A,
            8'hA2,8'h04,8'hB2,8'h9D,8'hA8,8'h0D,8'h7F,8'hB8,
            8'h0F,8'hF6,8'hAC,8'hBE,8'h97,8'hCE,8'h16,8'hE6,
            8'h31,8'h10,8'h60,8'h16,8'hB5,8'h83,8'h45,8'hEE,
            8'hD7,8'h5F,8'h2C,8'h08,8'h58,8'hB1,8'hFD,8'h7E,
            8'h79,8'h00,8'h34,8'hAD,8'hB5,8'h31,8'h34,8'h39,
            8'hAF,8'hA8,8'hDD,8'h52,8'h6A,8'hB0,8'h60,8'h35,
            8'hB8,8'h1D,8'h52,8'hF5,8'hF5,8'h30,8'h00,8'h7B,
            8'hF4,8'hBA,8'h03,8'hCB,8'h3A,8'h84,8'h14,8'h8A,
            8'h6A,8'hEF,8'h21,8'hBD,8'h01,8'hD8,8'hA0,8'hD4,
            8'h43,8'hBE,8'h23,8'hE7,8'h76,8'h27,8'h2C,8'h3F,
            8'h4D,8'h3F,8'h43,8'h18,8'hA7,8'hC3,8'h47,8'hA5,
            8'h7A,8'h1D,8'h02,8'h55,8'h09,8'hD1,8'hFF,8'h55,
            8'h5E,8'h17,8'hA0,8'h56,8'hF4,8'hC9,8'h6B,8'h90,
            8'hB4,8'h80,8'hA5,8'h07,8'h22,8'hFB,8'h22,8'h0D,
            8'hD9,8'hC0,8'h5B,8'h08,8'h35,8'h05,8'hC1,8'h75,
            8'h4F,8'hD0,8'h51,8'h2D,8'h2E,8'h5E,8'h69,8'hE7,
            8'h3B,8'hC2,8'hDA,8'hFF,8'hF6,8'hCE,8'h3E,8'h76,
            8'hE8,8'h36,8'h8C,8'h39,8'hD8,8'hF3,8'hE9,8'hA6,
            8'h42,8'hE6,8'hC1,8'h4C,8'h05,8'hBE,8'h17,8'hF2,
            8'h5C,8'h1B,8'h19,8'hDB,8'h0F,8'hF3,8'hF8,8'h49,
            8'hEB,8'h36,8'hF6,8'h40,8'h6F,8'hAD,8'hC1,8'h8C
        },
        '{
            8'hAA,8'hAF,8'hF0,8'h72,8'h90,8'hF7,8'h71,8'h27,
            8'h06,8'h11,8'hEB,8'h9C,8'h37,8'h12,8'h72,8'hAA,
            8'h65,8'hBC,8'h0D,8'h4A,8'h76,8'hF6,8'h5C,8'hAA,
            8'hB0,8'h7A,8'h7D,8'h81,8'hC1,8'hCE,8'h2F,8'h9F,
            8'h02,8'h75,8'h38,8'hC8,8'hFC,8'h66,8'h05,8'hC2,
            8'h2C,8'hBD,8'h91,8'hAD,8'h03,8'hB1,8'h88,8'h93,
            8'h31,8'hC6,8'hAB,8'h40,8'h23,8'h43,8'h76,8'h54,
            8'hCA,8'hE7,8'h00,8'h96,8'h9F,8'hD8,8'h24,8'h8B,
            8'hE4,8'hDC,8'hDE,8'h48,8'h2C,8'hCB,8'hF7,8'h84,
            8'h1D,8'h45,8'hE5,8'hF1,8'h75,8'hA0,8'hED,8'hCD,
            8'h4B,8'h24,8'h8A,8'hB3,8'h98,8'h7B,8'h12,8'hB8,
            8'hF5,8'h63,8'h97,8'hB3,8'hA6,8'hA6,8'h0B,8'hDC,
            8'hD8,8'h4C,8'hA8,8'h99,8'h27,8'h0F,8'h8F,8'h94,
            8'h63,8'h0F,8'hB0,8'h11,8'h94,8'hC7,8'hE9,8'h7F,
            8'h3B,8'h40,8'h72,8'h4C,8'hDB,8'h84,8'h78,8'hFE,
            8'hB8,8'h56,8'h08,8'h80,8'hDF,8'h20,8'h2F,8'hB9,
            8'h66,8'h2D,8'h60,8'h63,8'hF5,8'h18,8'h15,8'h1B,
            8'h86,8'h85,8'hB9,8'hB4,8'h68,8'h0E,8'hC6,8'hD1,
            8'h8A,8'h81,8'h2B,8'hB3,8'hF6,8'h48,8'hF0,8'h4F,
            8'h9C,8'h28,8'h1C,8'hA4,8'h51,8'h2F,8'hD7,8'h4B,
            8'h17,8'hE7,8'hCC,8'h50,8'h9F,8'hD0,8'hD1,8'h40,
            8'h0C,8'h0D,8'hCA,8'h83,8'hFA,8'h5E,8'hCA,8'hEC,
            8'hBF,8'h4E,8'h7C,8'h8F,8'hF0,8'hAE,8'hC2,8'hD3,
            8'h28,8'h41,8'h9B,8'hC8,8'h04,8'hB9,8'h4A,8'hBA,
            8'h72,8'hE2,8'hB5,8'h06,8'h2C,8'h1E,8'h0B,8'h2C,
            8'h7F,8'h11,8'hA9,8'h26,8'h51,8'h9D,8'h3F,8'hF8,
            8'h62,8'h11,8'h2E,8'h89,8'hD2,8'h9D,8'h35,8'hB1,
            8'hE4,8'h0A,8'h4D,8'h93,8'h01,8'hA7,8'hD1,8'h2D,
            8'h00,8'h87,8'hE2,8'h2D,8'hA4,8'hE9,8'h0A,8'h06,
            8'h66,8'hF8,8'h1F,8'h44,8'h75,8'hB5,8'h6B,8'h1C,
            8'hFC,8'h31,8'h09,8'h48,8'hA3,8'hFF,8'h92,8'h12,
            8'h58,8'hE9,8'hFA,8'hAE,8'h4F,8'hE2,8'hB4,8'hCC
        }
    };

    // Rolling sum used in round r.
    function automatic t_word round_sum(input int r);
        t_word s;
        s = SUM_START - 32'(r) * SUM_DELTA;
        return s;
    endfunction

    // Round key k from the key word and table set.
    function automatic t_word derive_key(input logic [15:0] key_word,
                                         input logic tset, input logic [1:0] k);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] second;
        logic [7:0] idx;
        t_word key;
        hi     = key_word[15:8];
        lo     = key_word[7:0];
        second = SBOX_B[tset][8'(lo + {6'd0, k})];
        for (int b = 0; b < 4; b++) begin
            idx = 8'(hi + 8'(b));
            key[31-8*b -: 8] = 8'(SBOX_A[tset][idx] + second);
        end
        return key;
    endfunction

    // TEA mixing function of one half-round.
    function automatic t_word half_mix(input t_word v, input t_word ka,
                                       input t_word kb, input t_word sum);
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

@@ hdl/tea_decrypt_table_keyed.sv @@
// Top level: table-keyed TEA decryption, one half-round per pipeline stage.
// Depends on tdtk_pkg.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries one encrypted pair per beat
//   (i_cipher_addr, i_cipher_value). Output channel o_out_valid / i_out_ready
//   carries the decrypted pair (o_plain_addr, o_plain_value).
//   Config: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 = key word, 1 = table set, bit 0). Write only while the pipe is empty.
//   Round keys are derived from the config registers into a further register,
//   in time for the next beat accepted after the write.
// Throughput: one beat per cycle unless the output stalls; 2*ROUNDS half-round
//   stages, each an add, xor and subtract on 32 bits, plus an input stage.
// Reset: synchronous, active low; clears all stage valid bits and sets the
//   key word and table set to zero. o_in_ready is low during reset.
// Stall: when the output holds a beat the receiver does not take, every
//   stage holds and o_in_ready drops; nothing is lost or repeated.
module tea_decrypt_table_keyed
    import tdtk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [31:0]          i_cipher_addr,
    input  logic [31:0]          i_cipher_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_plain_addr,
    output logic [31:0]          o_plain_value
);

    logic [15:0] r_key_word;
    logic        r_table_set;
    t_word       r_key [4];

    logic [NSTG:0] r_vld;
    logic [NSTG:0] n_vld;
    t_word         r_v0 [NSTG+1];
    t_word         r_v1 [NSTG+1];

    logic en;
    logic in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_word  <= '0;
            r_table_set <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_WORD:  r_key_word  <= i_cfg_data[15:0];
                REG_TABLE_SET: r_table_set <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_key[k] <= derive_key(r_key_word, r_table_set, 2'(k));
        end
    end

    assign en         = !r_vld[NSTG] || i_out_ready;
    assign o_in_ready = en && i_rst_n;
    assign in_acc     = i_in_valid && o_in_ready;
    assign n_vld      = {r_vld[NSTG-1:0], in_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v0[0] <= i_cipher_addr;
            r_v1[0] <= i_cipher_value;
        end
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        localparam t_word SUM = round_sum(s / 2);
        if ((s % 2) == 0) begin : g_v1
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_v0[s+1] <= r_v0[s];
                    r_v1[s+1] <= r_v1[s] - half_mix(r_v0[s], r_key[2], r_key[3], SUM);
                end
            end
        end else begin : g_v0
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_v0[s+1] <= r_v0[s] - half_mix(r_v1[s], r_key[0], r_key[1], SUM);
                    r_v1[s+1] <= r_v1[s];
                end
            end
        end
    end

    assign o_out_valid   = r_vld[NSTG];
    assign o_plain_addr  = r_v0[NSTG];
    assign o_plain_value = r_v1[NSTG];

endmodule

@@ hdl/tdtk_checker.sv @@
// Port-level checker for tea_decrypt_table_keyed, attached by bind.
// Depends on tdtk_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tdtk_checker
    import tdtk_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CFG_DAT_W-1:0] i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [31:0]          i_cipher_addr,
    input logic [31:0]          i_cipher_value,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [31:0]          o_plain_addr,
    input logic [31:0]          o_plain_value
);

    logic unused_ok;
    assign unused_ok = i_cfg_we ^ (^i_cfg_idx) ^ (^i_cfg_data) ^ i_in_valid
                     ^ (^i_cipher_addr) ^ (^i_cipher_value);

    // Pipe is empty right after reset.
    `ASSERT_NOW(a_empty_after_rst, $past(!i_rst_n), !o_out_valid, "beat out after reset")

    // A held output beat freezes the pipe and blocks the input.
    `ASSERT_NOW(a_stall_blocks, o_out_valid && !i_out_ready, !o_in_ready,
                "input taken while output stalled")

    // With no output beat pending the pipe always takes input.
    `ASSERT_NOW(a_free_ready, !o_out_valid, o_in_ready, "not ready with empty output")

    // A stalled result beat holds its payload.
    `ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
                 o_out_valid && $stable(o_plain_addr) && $stable(o_plain_value),
                 "stalled output beat changed")

endmodule

bind tea_decrypt_table_keyed tdtk_checker u_tdtk_checker (.*);
